### hdl/bcc_pkg.sv
// Shared types, constants and event codes for the button click classifier.
package bcc_pkg;

  localparam int NUM_KEYS     = 3;
  localparam int LEVELS_W     = 3;
  localparam int PRESS_W      = 7;
  localparam int WINDOW_W     = 8;
  localparam int CLICKS_W     = 2;
  localparam int KIND_W       = 2;
  localparam int KEY_W        = 2;
  localparam int CFG_INDEX_W  = 2;
  localparam int CFG_DATA_W   = 8;

  localparam logic [PRESS_W-1:0]  PRESS_CAP = 7'd120;
  localparam logic [CLICKS_W-1:0] CLICK_MAX = 2'd3;

  localparam logic [KIND_W-1:0] EV_NONE   = 2'd0;
  localparam logic [KIND_W-1:0] EV_SINGLE = 2'd1;
  localparam logic [KIND_W-1:0] EV_DOUBLE = 2'd2;
  localparam logic [KIND_W-1:0] EV_LONG   = 2'd3;

  localparam logic [CFG_INDEX_W-1:0] REG_DOUBLE_WINDOW = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_LONG_PRESS    = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_MIN_PRESS     = 2'd2;

  // Thresholds as the cells see them, already forced to at least one.
  typedef struct packed {
    logic [WINDOW_W-1:0] double_window;
    logic [PRESS_W-1:0]  long_press_ticks;
    logic [PRESS_W-1:0]  min_press_ticks;
  } cfg_t;

  // Event handed along the row of cells.
  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [KEY_W-1:0]  key;
  } event_t;

endpackage

### hdl/button_click_classifier_unit.sv
// Top level of the button click classifier: config registers, cell row, output register.
//
// Usage:
//   The slave stream carries one scan tick per transaction: s_tdata[2:0] holds
//   the active-low levels of the buttons (0 pressed). Every tick yields exactly
//   one result transaction on the master stream: m_tdata[1:0] is the event
//   kind (none, single, double, long) and m_tdata[3:2] the button index.
//   Each button has a cell of its own; the cells form a row and hand the
//   pending event on from button 0 upwards, so the highest-numbered button
//   that reports on a tick wins.
//   The result is registered and appears in the output register in the cycle
//   after the tick is taken. Throughput: one tick per cycle while the receiver
//   takes results, set by the single output register, which is refilled in
//   the same cycle that it is emptied. When the receiver stalls with a result
//   held, s_tready drops and all button state holds until the result is taken.
//   Reset (rst, synchronous, active high) clears all button state, empties the
//   output register and loads the thresholds with 30, 100 and 2.
//   Config writes (cfg_we, cfg_index, cfg_data) take effect on the next tick;
//   an index beyond the last register is ignored.
module button_click_classifier_unit
  import bcc_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  // Config write port
  input  logic                   cfg_we,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  // Scan tick stream
  input  logic                   s_tvalid,
  output logic                   s_tready,
  input  logic [7:0]             s_tdata,   // [2:0] key_levels
  // Event stream
  output logic                   m_tvalid,
  input  logic                   m_tready,
  output logic [7:0]             m_tdata    // [1:0] event_kind, [3:2] event_key
);

  logic [WINDOW_W-1:0] double_window;
  logic [PRESS_W-1:0]  long_press_ticks;
  logic [PRESS_W-1:0]  min_press_ticks;
  cfg_t                cfg;
  logic                advance;
  event_t              chain [NUM_KEYS+1];
  event_t              out_event;

  // Config registers; the user must write them only while the block is idle, the block does not enforce it.
  always_ff @(posedge clk) begin
    if (rst) begin
      double_window    <= 8'd30;
      long_press_ticks <= 7'd100;
      min_press_ticks  <= 7'd2;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_DOUBLE_WINDOW: double_window    <= cfg_data;
        REG_LONG_PRESS:    long_press_ticks <= cfg_data[PRESS_W-1:0];
        REG_MIN_PRESS:     min_press_ticks  <= cfg_data[PRESS_W-1:0];
        default: ;
      endcase
    end
  end

  // Treat a zero threshold as one.
  always_comb begin
    cfg.double_window    = (double_window == '0) ? WINDOW_W'(1) : double_window;
    cfg.long_press_ticks = (long_press_ticks == '0) ? PRESS_W'(1) : long_press_ticks;
    cfg.min_press_ticks  = (min_press_ticks == '0) ? PRESS_W'(1) : min_press_ticks;
  end

  // Accept a tick whenever the output register is empty or being emptied.
  assign s_tready = !m_tvalid || m_tready;
  assign advance  = s_tvalid && s_tready;

  assign chain[0] = '{kind: EV_NONE, key: '0};

  for (genvar k = 0; k < NUM_KEYS; k++) begin : g_cell
    logic pressed;
    // Buttons beyond the level field read as released.
    if (k < LEVELS_W) begin : g_pin
      assign pressed = !s_tdata[k];
    end else begin : g_nopin
      assign pressed = 1'b0;
    end

    bcc_cell u_cell (
      .clk       (clk),
      .rst       (rst),
      .advance   (advance),
      .pressed   (pressed),
      .key_index (KEY_W'(k)),
      .cfg       (cfg),
      .ev_in     (chain[k]),
      .ev_out    (chain[k+1])
    );
  end

  // Output register: load on accept, drop once taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (advance) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_event <= chain[NUM_KEYS];
    end
  end

  assign m_tdata = {4'b0000, out_event.key, out_event.kind};

endmodule

### hdl/bcc_cell.sv
// One button cell: press counter, click window and event hand-on.
module bcc_cell
  import bcc_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  logic         advance,
  input  logic         pressed,
  input  logic [KEY_W-1:0] key_index,
  input  cfg_t         cfg,
  input  event_t       ev_in,
  output event_t       ev_out
);

  logic [PRESS_W-1:0]  press_ticks,    press_ticks_next;
  logic [WINDOW_W-1:0] window_left,    window_left_next;
  logic [CLICKS_W-1:0] click_count,    click_count_next;
  logic                clicks_pending, clicks_pending_next;
  logic [KIND_W-1:0]   kind;
  logic [PRESS_W:0]    press_inc;

  assign press_inc = {1'b0, press_ticks} + {{PRESS_W{1'b0}}, 1'b1};

  always_comb begin
    press_ticks_next    = press_ticks;
    window_left_next    = window_left;
    click_count_next    = click_count;
    clicks_pending_next = clicks_pending;
    kind                = EV_NONE;
    if (pressed) begin
      if (press_inc >= {1'b0, PRESS_CAP}) begin
        press_ticks_next = PRESS_CAP;
      end else begin
        press_ticks_next = press_inc[PRESS_W-1:0];
      end
    end else begin
      if (press_ticks >= cfg.long_press_ticks && !clicks_pending) begin
        kind = EV_LONG;
      end else if (press_ticks >= cfg.min_press_ticks) begin
        if (click_count != CLICK_MAX) begin
          click_count_next = click_count + 1'b1;
        end
        window_left_next    = cfg.double_window;
        clicks_pending_next = 1'b1;
      end
      press_ticks_next = '0;
      // Count the window down on every released tick; report on expiry.
      if (window_left_next != '0) begin
        window_left_next = window_left_next - 1'b1;
        if (window_left_next == '0) begin
          if (click_count_next == 2'd1) begin
            kind = EV_SINGLE;
          end else if (click_count_next == 2'd2) begin
            kind = EV_DOUBLE;
          end
          click_count_next    = '0;
          clicks_pending_next = 1'b0;
        end
      end
    end
  end

  // Higher-numbered cells sit further down the row, so they override.
  always_comb begin
    if (kind != EV_NONE) begin
      ev_out.kind = kind;
      ev_out.key  = key_index;
    end else begin
      ev_out = ev_in;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      press_ticks    <= '0;
      window_left    <= '0;
      click_count    <= '0;
      clicks_pending <= 1'b0;
    end else if (advance) begin
      press_ticks    <= press_ticks_next;
      window_left    <= window_left_next;
      click_count    <= click_count_next;
      clicks_pending <= clicks_pending_next;
    end
  end

endmodule

### dv/tb_top.sv
// Self-checking testbench for the button click classifier: scripted presses, random stalls.
module tb_top;
  import bcc_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  // Index past the last register; writes to it must leave every threshold alone.
  localparam logic [CFG_INDEX_W-1:0] REG_UNUSED = 2'd3;
  // Cycles without any transaction or register write before the run is declared hung.
  localparam int IDLE_LIMIT = 600;

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   cfg_we = 1'b0;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0]  cfg_data = '0;
  logic                   s_tvalid = 1'b0;
  logic                   s_tready;
  logic [7:0]             s_tdata = '0;   // [2:0] key_levels
  logic                   m_tvalid;
  logic                   m_tready = 1'b0;
  logic [7:0]             m_tdata;        // [1:0] event_kind, [3:2] event_key

  button_click_classifier_unit i_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Predictor: thresholds and per-button state as the block should hold them
  // ---------------------------------------------------------------------------
  logic [WINDOW_W-1:0] window_reg = 8'd30;
  logic [PRESS_W-1:0]  long_reg   = 7'd100;
  logic [PRESS_W-1:0]  min_reg    = 7'd2;

  logic [PRESS_W-1:0]  press_cnt  [NUM_KEYS] = '{default: '0};
  logic [WINDOW_W-1:0] window_cnt [NUM_KEYS] = '{default: '0};
  logic [CLICKS_W-1:0] click_cnt  [NUM_KEYS] = '{default: '0};
  logic                group_open [NUM_KEYS] = '{default: 1'b0};

  // A threshold of zero behaves as one.
  function automatic int floor_one(input int v);
    return (v == 0) ? 1 : v;
  endfunction

  // Advance every button by one scan tick and return the event the block reports.
  function automatic event_t classify_tick(input logic [LEVELS_W-1:0] levels);
    event_t            ev;
    logic [KIND_W-1:0] key_ev;
    ev.kind = EV_NONE;
    ev.key  = '0;
    for (int k = 0; k < NUM_KEYS; k++) begin
      key_ev = EV_NONE;
      if (!levels[k]) begin
        // Held: count up, saturating at the cap
        if (press_cnt[k] < PRESS_CAP) press_cnt[k] = press_cnt[k] + 1'b1;
      end else begin
        // Released: classify the press that just ended
        if (press_cnt[k] >= floor_one(long_reg) && !group_open[k]) begin
          key_ev = EV_LONG;
        end else if (press_cnt[k] >= floor_one(min_reg)) begin
          if (click_cnt[k] != CLICK_MAX) click_cnt[k] = click_cnt[k] + 1'b1;
          window_cnt[k] = WINDOW_W'(floor_one(window_reg));
          group_open[k] = 1'b1;
        end
        press_cnt[k] = '0;
        // The window only runs on released ticks, starting with the one that loads it
        if (window_cnt[k] != 0) begin
          window_cnt[k] = window_cnt[k] - 1'b1;
          if (window_cnt[k] == 0) begin
            if (click_cnt[k] == 2'd1)      key_ev = EV_SINGLE;
            else if (click_cnt[k] == 2'd2) key_ev = EV_DOUBLE;
            click_cnt[k]  = '0;
            group_open[k] = 1'b0;
          end
        end
      end
      // Higher-numbered buttons override lower ones
      if (key_ev != EV_NONE) begin
        ev.kind = key_ev;
        ev.key  = KEY_W'(k);
      end
    end
    return ev;
  endfunction

  // ---------------------------------------------------------------------------
  // Queues, handshake flags and idling controls
  // ---------------------------------------------------------------------------
  logic [LEVELS_W-1:0] scan_q [$];
  event_t              due_events [$];

  logic tick_fire  = 1'b0;   // a scan tick transaction completed at the last rising edge
  logic event_fire = 1'b0;   // an event transaction completed at the last rising edge
  int   gap_max    = 0;
  int   stall_max  = 0;
  int   fail_cnt   = 0;
  int   ticks_sent = 0;
  int   kind_seen  [4] = '{default: 0};

  // ---------------------------------------------------------------------------
  // Scan tick driver: present one tick at a time, idle a random gap after each
  // ---------------------------------------------------------------------------
  logic tick_held = 1'b0;
  int   tick_gap  = 0;

  always @(negedge clk) begin
    if (tick_held && tick_fire) begin
      tick_held = 1'b0;
      tick_gap  = $urandom_range(0, gap_max);
    end
    if (!tick_held) begin
      if (tick_gap > 0) begin
        tick_gap--;
      end else if (scan_q.size() > 0) begin
        s_tdata   <= {{(8-LEVELS_W){1'b0}}, scan_q.pop_front()};
        tick_held = 1'b1;
      end
    end
    // One assignment per edge, so a back-to-back tick keeps tvalid high
    s_tvalid <= tick_held;
  end

  // ---------------------------------------------------------------------------
  // Event receiver: stall for a random number of cycles after each transaction
  // ---------------------------------------------------------------------------
  int rx_stall = 0;

  always @(negedge clk) begin
    if (event_fire) rx_stall = $urandom_range(0, stall_max);
    if (rx_stall > 0) begin
      m_tready <= 1'b0;
      rx_stall--;
    end else begin
      m_tready <= 1'b1;
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: check each event against the oldest prediction, then predict
  // for the tick taken at this edge
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    event_t want;
    if (rst) begin
      tick_fire  <= 1'b0;
      event_fire <= 1'b0;
    end else begin
      tick_fire  <= s_tvalid && s_tready;
      event_fire <= m_tvalid && m_tready;
      if (m_tvalid && m_tready) begin
        if (due_events.size() == 0) begin
          $error("event transaction with nothing predicted: tdata 0x%02h", m_tdata);
          fail_cnt++;
        end else begin
          want = due_events.pop_front();
          kind_seen[want.kind]++;
          if (m_tdata[KIND_W-1:0] !== want.kind) begin
            $error("event_kind: expected %0d, got %0d", want.kind, m_tdata[KIND_W-1:0]);
            fail_cnt++;
          end
          if (m_tdata[KIND_W+KEY_W-1:KIND_W] !== want.key) begin
            $error("event_key: expected %0d, got %0d", want.key,
                   m_tdata[KIND_W+KEY_W-1:KIND_W]);
            fail_cnt++;
          end
          if (m_tdata[7:KIND_W+KEY_W] !== '0) begin
            $error("tdata padding: expected 0, got 0x%0h", m_tdata[7:KIND_W+KEY_W]);
            fail_cnt++;
          end
        end
      end
      if (s_tvalid && s_tready) begin
        due_events.push_back(classify_tick(s_tdata[LEVELS_W-1:0]));
        ticks_sent++;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Watchdog: give up once nothing has moved for too long
  // ---------------------------------------------------------------------------
  initial begin
    int quiet;
    quiet = 0;
    while (quiet < IDLE_LIMIT) begin
      @(posedge clk);
      if (rst || cfg_we || (s_tvalid && s_tready) || (m_tvalid && m_tready)) quiet = 0;
      else quiet++;
    end
    $display("tb_top: timeout after %0d quiet cycles", IDLE_LIMIT);
    $display("tb_top: FAIL");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------

  // Write one register and mirror it in the predictor; only called while idle.
  task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] val);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    case (idx)
      REG_DOUBLE_WINDOW: window_reg = val;
      REG_LONG_PRESS:    long_reg   = val[PRESS_W-1:0];
      REG_MIN_PRESS:     min_reg    = val[PRESS_W-1:0];
      default: ;         // unused index: drop
    endcase
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // Hold off until every queued tick is taken and every predicted event has arrived.
  task automatic drain();
    while (scan_q.size() != 0 || s_tvalid || due_events.size() != 0) @(posedge clk);
  endtask

  // Drain, load a new threshold set and new idling limits.
  task automatic set_phase(input logic [7:0] win, input logic [7:0] lng, input logic [7:0] mn,
                           input int gmax, input int smax);
    drain();
    write_reg(REG_DOUBLE_WINDOW, win);
    write_reg(REG_LONG_PRESS, lng);
    write_reg(REG_MIN_PRESS, mn);
    gap_max   = gmax;
    stall_max = smax;
  endtask

  task automatic push_ticks(input logic [LEVELS_W-1:0] lv, input int n);
    repeat (n) scan_q.push_back(lv);
  endtask

  // Press lengths picked around the current thresholds.
  function automatic int pick_hold_len();
    int lo_min;
    int lo_long;
    lo_min  = floor_one(min_reg);
    lo_long = floor_one(long_reg);
    case ($urandom_range(0, 5))
      0:       return (lo_min > 1) ? $urandom_range(1, (lo_min - 1 < 6) ? lo_min - 1 : 6) : 1;
      1, 2:    return $urandom_range(lo_min, lo_min + 2);
      3:       return (lo_long > lo_min + 1) ? $urandom_range(lo_min, lo_long - 1) : lo_min;
      4:       return $urandom_range(lo_long, lo_long + 2);
      default: return $urandom_range(1, 4);
    endcase
  endfunction

  // Release lengths: mostly inside the window to build groups, sometimes past it.
  function automatic int pick_release_len();
    int win;
    win = floor_one(window_reg);
    case ($urandom_range(0, 3))
      0, 1:    return $urandom_range(1, (win > 1) ? win - 1 : 1);
      2:       return $urandom_range(win, win + 3);
      default: return $urandom_range(1, 3);
    endcase
  endfunction

  // Each button follows its own press/release script; one tick in ten is noise.
  int  run_left [NUM_KEYS] = '{default: 0};
  logic run_down [NUM_KEYS] = '{default: 1'b1};

  task automatic push_scripted(input int n);
    logic [LEVELS_W-1:0] lv;
    for (int i = 0; i < n; i++) begin
      for (int k = 0; k < NUM_KEYS; k++) begin
        if (run_left[k] == 0) begin
          run_down[k] = !run_down[k];
          run_left[k] = run_down[k] ? pick_hold_len() : pick_release_len();
        end
        run_left[k]--;
        lv[k] = !run_down[k];
      end
      if ($urandom_range(0, 9) == 0) lv = LEVELS_W'($urandom_range(0, 7));
      scan_q.push_back(lv);
    end
  endtask

  // ---------------------------------------------------------------------------
  // Test sequence
  // ---------------------------------------------------------------------------
  initial begin
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed: one of each event kind on short thresholds (levels are active low)
    set_phase(8'd2, 8'd4, 8'd1, 18, 18);
    push_ticks(3'b110, 1);              // single click on button 0
    push_ticks(3'b111, 2);
    push_ticks(3'b101, 1);              // double click on button 1
    push_ticks(3'b111, 1);
    push_ticks(3'b101, 1);
    push_ticks(3'b111, 2);
    push_ticks(3'b011, 4);              // long press on button 2
    push_ticks(3'b111, 1);
    push_ticks(3'b000, 4);              // all three long at once, button 2 wins
    push_ticks(3'b111, 1);
    repeat (3) begin                    // three clicks in one group report nothing
      push_ticks(3'b110, 1);
      push_ticks(3'b111, 1);
    end
    push_ticks(3'b111, 1);

    // Mid-range thresholds, sender idles, receiver never stalls
    set_phase(8'd4, 8'd8, 8'd2, 18, 0);
    push_scripted(150);

    // All thresholds zero, treated as one; no idling on either side
    set_phase(8'd0, 8'd0, 8'd0, 0, 0);
    push_scripted(60);

    // Out-of-range index must change nothing
    drain();
    write_reg(REG_UNUSED, 8'hFF);

    // Shortest window with both press thresholds at the cap
    set_phase(8'd1, 8'd120, 8'd120, 0, 18);
    push_scripted(260);

    // Widest window, long press out of reach
    set_phase(8'd255, 8'd127, 8'd1, 3, 3);
    push_scripted(250);

    // Click threshold out of reach, only long presses possible
    set_phase(8'd3, 8'd5, 8'd127, 18, 18);
    drain();
    write_reg(REG_UNUSED, 8'h00);
    push_scripted(80);

    // Long threshold just above the click threshold, against a short window
    set_phase(8'd6, 8'd2, 8'd1, 18, 18);
    push_scripted(150);

    drain();
    repeat (4) @(posedge clk);

    $display("tb_top: %0d scan ticks checked over seven threshold sets", ticks_sent);
    $display("tb_top: events seen - none %0d, single %0d, double %0d, long %0d",
             kind_seen[EV_NONE], kind_seen[EV_SINGLE], kind_seen[EV_DOUBLE],
             kind_seen[EV_LONG]);
    if (fail_cnt == 0) begin
      $display("tb_top: PASS");
    end else begin
      $display("tb_top: FAIL");
    end
    $finish;
  end

endmodule
